### hw/rtl/vfl_pkg.sv
// Shared constants, field widths and register codes for the viewport fit block.
// Used by viewport_fit_letterbox_unit and the testbench tb_top; depends on nothing.
`timescale 1ns / 1ps

package vfl_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int WINDOW_BITS   = 13;

  localparam int WIN_W  = WINDOW_BITS + 1;
  localparam int PTR_W  = WINDOW_BITS;
  localparam int FRM_W  = 13;
  localparam int ACT_W  = 12;
  localparam int SCL_W  = 24;
  localparam int RECT_W = 16;
  localparam int SRC_W  = 24;
  localparam int SRC_FB = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [SCL_W-1:0] QONE = SCL_W'(64'd1 << FRACTION_BITS);

  localparam logic [FRM_W-1:0] RST_FRAME_WIDTH   = FRM_W'(640);
  localparam logic [FRM_W-1:0] RST_FRAME_HEIGHT  = FRM_W'(480);
  localparam logic [ACT_W-1:0] RST_ACTIVE_LEFT   = ACT_W'(0);
  localparam logic [ACT_W-1:0] RST_ACTIVE_TOP    = ACT_W'(0);
  localparam logic [FRM_W-1:0] RST_ACTIVE_WIDTH  = FRM_W'(640);
  localparam logic [FRM_W-1:0] RST_ACTIVE_HEIGHT = FRM_W'(480);
  localparam logic [SCL_W-1:0] RST_TARGET_ASPECT = SCL_W'(87381);
  localparam logic [1:0]       RST_FIT_MODE      = 2'd0;

  localparam int MODE_STRETCH = 0;
  localparam int MODE_INTEGER = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH   = 3'd0,
    CFG_FRAME_HEIGHT  = 3'd1,
    CFG_ACTIVE_LEFT   = 3'd2,
    CFG_ACTIVE_TOP    = 3'd3,
    CFG_ACTIVE_WIDTH  = 3'd4,
    CFG_ACTIVE_HEIGHT = 3'd5,
    CFG_TARGET_ASPECT = 3'd6,
    CFG_FIT_MODE      = 3'd7
  } cfg_idx_t;

endpackage

### hw/rtl/vfl_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Carries a valid bit and a side payload alongside; uses no package items.
`timescale 1ns / 1ps

module vfl_div #(
  parameter int N  = 32,
  parameter int D  = 16,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [N-1:0]  in_num,
  input  logic [D-1:0]  in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [N-1:0]  out_quo,
  output logic [SW-1:0] out_side
);

  logic [D-1:0]  rem_r  [N];
  logic [N-1:0]  num_r  [N];
  logic [N-1:0]  quo_r  [N];
  logic [D-1:0]  den_r  [N];
  logic [SW-1:0] side_r [N];
  logic [N-1:0]  v_r;

  logic [D-1:0]  rem_p  [N];
  logic [N-1:0]  num_p  [N];
  logic [N-1:0]  quo_p  [N];
  logic [D-1:0]  den_p  [N];
  logic [SW-1:0] side_p [N];
  logic [N-1:0]  v_p;
  logic [D-1:0]  rem_nxt [N];
  logic [N-1:0]  ge;

  always_comb begin
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        rem_p[k]  = '0;
        num_p[k]  = in_num;
        quo_p[k]  = '0;
        den_p[k]  = in_den;
        side_p[k] = in_side;
        v_p[k]    = in_valid;
      end else begin
        rem_p[k]  = rem_r[k-1];
        num_p[k]  = num_r[k-1];
        quo_p[k]  = quo_r[k-1];
        den_p[k]  = den_r[k-1];
        side_p[k] = side_r[k-1];
        v_p[k]    = v_r[k-1];
      end
    end
  end

  always_comb begin
    logic [D:0] trial;
    logic [D:0] diff;
    for (int k = 0; k < N; k++) begin
      trial = {rem_p[k], num_p[k][N-1]};
      diff  = trial - {1'b0, den_p[k]};
      ge[k] = trial >= {1'b0, den_p[k]};
      rem_nxt[k] = ge[k] ? diff[D-1:0] : trial[D-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= v_p;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        rem_r[k]  <= rem_nxt[k];
        num_r[k]  <= num_p[k] << 1;
        quo_r[k]  <= {quo_p[k][N-2:0], ge[k]};
        den_r[k]  <= den_p[k];
        side_r[k] <= side_p[k];
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign out_quo   = quo_r[N-1];
  assign out_side  = side_r[N-1];

endmodule

### hw/rtl/viewport_fit_letterbox_unit.sv
// Top level of the viewport fit block: letterbox fit, rectangle and pointer mapping.
// Depends on vfl_pkg and on the pipelined divider vfl_div.
`timescale 1ns / 1ps
//
//   Channel   Direction   Handshake            Payload
//   in_       request in  in_valid / in_ready  window size, margin, aspect flag, pointer
//   out_      request out out_valid/out_ready  rectangle, scales, source pointer
//   cfg_      write in    cfg_we               cfg_index, cfg_data
//
// One request enters every cycle unless a held result in the output register stalls the pipeline.
// Five divider chains lie in series (30, 37, 46, 46 and 49 quotient bits, one bit per
// stage) and eleven further register stages hold the fit logic and the output register.
// Reset clears all valid bits and loads the register defaults; there is no clearing pass.
// The whole pipeline advances whenever the output register is empty or being taken.

module viewport_fit_letterbox_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [vfl_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [vfl_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [vfl_pkg::WIN_W-1:0]             in_window_w,
  input  logic [vfl_pkg::WIN_W-1:0]             in_window_h,
  input  logic [vfl_pkg::PTR_W-1:0]             in_margin_top,
  input  logic                                  in_use_aspect,
  input  logic [vfl_pkg::PTR_W-1:0]             in_pointer_x,
  input  logic [vfl_pkg::PTR_W-1:0]             in_pointer_y,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [vfl_pkg::RECT_W-1:0]            out_rect_left,
  output logic [vfl_pkg::RECT_W-1:0]            out_rect_top,
  output logic [vfl_pkg::RECT_W-1:0]            out_rect_width,
  output logic [vfl_pkg::RECT_W-1:0]            out_rect_height,
  output logic [vfl_pkg::SCL_W-1:0]             out_fit_scale,
  output logic [vfl_pkg::SCL_W-1:0]             out_horiz_scale,
  output logic signed [vfl_pkg::SRC_W-1:0]      out_source_x,
  output logic signed [vfl_pkg::SRC_W-1:0]      out_source_y
);

  localparam int FB     = vfl_pkg::FRACTION_BITS;
  localparam int WIN_W  = vfl_pkg::WIN_W;
  localparam int PTR_W  = vfl_pkg::PTR_W;
  localparam int FRM_W  = vfl_pkg::FRM_W;
  localparam int ACT_W  = vfl_pkg::ACT_W;
  localparam int SCL_W  = vfl_pkg::SCL_W;
  localparam int RECT_W = vfl_pkg::RECT_W;
  localparam int SRC_W  = vfl_pkg::SRC_W;
  localparam int SRC_FB = vfl_pkg::SRC_FB;

  localparam int WQ_W   = WIN_W + FB;
  localparam int PB_W   = SCL_W + FRM_W;
  localparam int DW_W   = FRM_W + SCL_W;
  localparam int LHS_W  = DW_W + WIN_W;
  localparam int RHS_W  = WQ_W + FRM_W;
  localparam int C_N    = WIN_W + 2 * FB;
  localparam int DWS_W  = DW_W + SCL_W;
  localparam int FHS_W  = FRM_W + SCL_W;
  localparam int PAD_W  = WQ_W;
  localparam int ALX_W  = ACT_W + SCL_W;
  localparam int AWX_W  = FRM_W + SCL_W;
  localparam int ALXS_W = ALX_W + SCL_W;
  localparam int AWXS_W = AWX_W + SCL_W;
  localparam int ATS_W  = ACT_W + SCL_W;
  localparam int AHS_W  = FRM_W + SCL_W;
  localparam int NUM_W  = WQ_W;
  localparam int D_N    = NUM_W + FB;
  localparam int Q1_W   = 41;
  localparam int E_N    = Q1_W + SRC_FB;

  localparam logic [Q1_W-1:0]  Q1_MAX = Q1_W'(64'd1 << (Q1_W - 1));
  localparam logic [SCL_W-1:0] QMAX   = '1;
  localparam logic [SRC_W-1:0] SPOS   = {1'b0, {(SRC_W-1){1'b1}}};
  localparam logic [SRC_W-1:0] SNEG   = {1'b1, {(SRC_W-1){1'b0}}};

  typedef struct packed {
    logic [WIN_W-1:0] w;
    logic [WIN_W-1:0] h;
    logic [PTR_W-1:0] m;
    logic             use_aspect;
    logic [PTR_W-1:0] px;
    logic [PTR_W-1:0] py;
  } item_t;

  typedef struct packed {
    item_t            it;
    logic [SCL_W-1:0] xs_a;
    logic [SCL_W-1:0] xs_r;
    logic [DW_W-1:0]  dw_a;
    logic [DW_W-1:0]  dw_r;
  } fitx_t;

  typedef struct packed {
    fitx_t fx;
    logic  cond_a;
  } cside_t;

  typedef struct packed {
    item_t            it;
    logic [SCL_W-1:0] xs_a;
    logic             cond_a;
    logic             cond_r;
    logic [SCL_W-1:0] s_a;
    logic [DWS_W-1:0] dws_a;
    logic [FHS_W-1:0] fhs_a;
    logic [DWS_W-1:0] dws_r;
    logic [FHS_W-1:0] fhs_r;
    logic [ALX_W-1:0] alxs;
    logic [AWX_W-1:0] awxs;
    logic [ATS_W-1:0] ats;
    logic [AHS_W-1:0] ahs;
    logic [SCL_W-1:0] s_r;
  } prod_t;

  typedef struct packed {
    item_t             it;
    logic [SCL_W-1:0]  xs_a;
    logic [SCL_W-1:0]  s_a;
    logic [PAD_W-1:0]  padx_a;
    logic [PAD_W-1:0]  pady_a;
    logic [PAD_W-1:0]  padx_r;
    logic [PAD_W-1:0]  pady_r;
    logic [ALXS_W-1:0] alxss;
    logic [AWXS_W-1:0] awxss;
    logic [ATS_W-1:0]  ats;
    logic [AHS_W-1:0]  ahs;
  } pad_t;

  typedef struct packed {
    logic [RECT_W-1:0] rect_left;
    logic [RECT_W-1:0] rect_top;
    logic [RECT_W-1:0] rect_width;
    logic [RECT_W-1:0] rect_height;
    logic [SCL_W-1:0]  fit_scale;
    logic [SCL_W-1:0]  horiz_scale;
    logic              neg_x;
    logic              nz_x;
  } dside_t;

  typedef struct packed {
    logic neg_y;
    logic nz_y;
  } fside_t;

  typedef struct packed {
    dside_t           d;
    logic [SRC_W-1:0] sy;
    logic             q1_nz;
  } eside_t;

  typedef struct packed {
    logic [RECT_W-1:0] rect_left;
    logic [RECT_W-1:0] rect_top;
    logic [RECT_W-1:0] rect_width;
    logic [RECT_W-1:0] rect_height;
    logic [SCL_W-1:0]  fit_scale;
    logic [SCL_W-1:0]  horiz_scale;
    logic [SRC_W-1:0]  source_x;
    logic [SRC_W-1:0]  source_y;
  } res_t;

  function automatic logic [SCL_W-1:0] sat_scl(input logic [63:0] v);
    return (v > 64'(QMAX)) ? QMAX : v[SCL_W-1:0];
  endfunction

  function automatic logic [RECT_W-1:0] sat_rect(input logic [63:0] v);
    return (v > 64'({RECT_W{1'b1}})) ? {RECT_W{1'b1}} : v[RECT_W-1:0];
  endfunction

  function automatic logic [PAD_W-1:0] half_pos(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] d;
    d = (a - b) >> 1;
    return (a > b) ? d[PAD_W-1:0] : '0;
  endfunction

  function automatic logic [SRC_W-1:0] sgn_out(input logic neg, input logic [E_N-1:0] mag);
    logic [SRC_W-1:0] m2;
    if (neg) begin
      m2 = (mag > E_N'(SNEG)) ? SNEG : mag[SRC_W-1:0];
      return SRC_W'(0) - m2;
    end
    return (mag > E_N'(SPOS)) ? SPOS : mag[SRC_W-1:0];
  endfunction

  // Configuration registers.
  logic [FRM_W-1:0] fw_r, fh_r, aw_r, ah_r;
  logic [ACT_W-1:0] al_r, at_r;
  logic [SCL_W-1:0] ta_r;
  logic [1:0]       mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r   <= vfl_pkg::RST_FRAME_WIDTH;
      fh_r   <= vfl_pkg::RST_FRAME_HEIGHT;
      al_r   <= vfl_pkg::RST_ACTIVE_LEFT;
      at_r   <= vfl_pkg::RST_ACTIVE_TOP;
      aw_r   <= vfl_pkg::RST_ACTIVE_WIDTH;
      ah_r   <= vfl_pkg::RST_ACTIVE_HEIGHT;
      ta_r   <= vfl_pkg::RST_TARGET_ASPECT;
      mode_r <= vfl_pkg::RST_FIT_MODE;
    end else if (cfg_we) begin
      case (cfg_index)
        vfl_pkg::CFG_FRAME_WIDTH:   fw_r   <= cfg_data[FRM_W-1:0];
        vfl_pkg::CFG_FRAME_HEIGHT:  fh_r   <= cfg_data[FRM_W-1:0];
        vfl_pkg::CFG_ACTIVE_LEFT:   al_r   <= cfg_data[ACT_W-1:0];
        vfl_pkg::CFG_ACTIVE_TOP:    at_r   <= cfg_data[ACT_W-1:0];
        vfl_pkg::CFG_ACTIVE_WIDTH:  aw_r   <= cfg_data[FRM_W-1:0];
        vfl_pkg::CFG_ACTIVE_HEIGHT: ah_r   <= cfg_data[FRM_W-1:0];
        vfl_pkg::CFG_TARGET_ASPECT: ta_r   <= cfg_data[SCL_W-1:0];
        vfl_pkg::CFG_FIT_MODE:      mode_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic [FRM_W-1:0] fw_e, fh_e;
  logic             stretch, integ;

  assign fw_e    = (fw_r == '0) ? FRM_W'(1) : fw_r;
  assign fh_e    = (fh_r == '0) ? FRM_W'(1) : fh_r;
  assign stretch = mode_r[vfl_pkg::MODE_STRETCH];
  assign integ   = mode_r[vfl_pkg::MODE_INTEGER];

  logic en;
  logic out_valid_r;
  res_t res_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // Stage 1: input capture and effective height.
  item_t s1_r, s1_nxt;
  logic  s1_v_r;

  always_comb begin
    s1_nxt.w          = in_window_w;
    s1_nxt.h          = (in_window_h > WIN_W'(in_margin_top)) ?
                        in_window_h - WIN_W'(in_margin_top) : WIN_W'(1);
    s1_nxt.m          = in_margin_top;
    s1_nxt.use_aspect = in_use_aspect;
    s1_nxt.px         = in_pointer_x;
    s1_nxt.py         = in_pointer_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
    end
  end

  // Window ratio.
  logic            a_v;
  logic [WQ_W-1:0] a_q;
  item_t           a_side;

  vfl_div #(.N(WQ_W), .D(WIN_W), .SW($bits(item_t))) u_div_ratio (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s1_v_r),
    .in_num   ({s1_r.w, {FB{1'b0}}}),
    .in_den   (s1_r.h),
    .in_side  (s1_r),
    .out_valid(a_v),
    .out_quo  (a_q),
    .out_side (a_side)
  );

  // Stage 2: display aspect times frame height.
  logic [SCL_W-1:0] da;
  logic [PB_W-1:0]  pb_r, pb_nxt;
  item_t            s2_r;
  logic             s2_v_r;

  assign da     = stretch ? sat_scl(64'(a_q)) : ta_r;
  assign pb_nxt = PB_W'(da) * PB_W'(fh_e);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pb_r <= pb_nxt;
      s2_r <= a_side;
    end
  end

  // Horizontal scale.
  logic            b_v;
  logic [PB_W-1:0] b_q;
  item_t           b_side;

  vfl_div #(.N(PB_W), .D(FRM_W), .SW($bits(item_t))) u_div_xscale (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s2_v_r),
    .in_num   (pb_r),
    .in_den   (fw_e),
    .in_side  (s2_r),
    .out_valid(b_v),
    .out_quo  (b_q),
    .out_side (b_side)
  );

  // Stage 3: x scales and display widths for both fits.
  fitx_t s3_r, s3_nxt;
  logic  s3_v_r;

  always_comb begin
    s3_nxt.it   = b_side;
    s3_nxt.xs_a = sat_scl(64'(b_q));
    s3_nxt.xs_r = b_side.use_aspect ? s3_nxt.xs_a : vfl_pkg::QONE;
    s3_nxt.dw_a = DW_W'(fw_e) * DW_W'(s3_nxt.xs_a);
    s3_nxt.dw_r = DW_W'(fw_e) * DW_W'(s3_nxt.xs_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r <= s3_nxt;
    end
  end

  // Stage 4: cross products for the limiting-axis test.
  fitx_t            s4_r;
  logic             s4_v_r;
  logic [LHS_W-1:0] lhs_a_r, lhs_r_r;
  logic [RHS_W-1:0] rhs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_r    <= s3_r;
      lhs_a_r <= LHS_W'(s3_r.dw_a) * LHS_W'(s3_r.it.h);
      lhs_r_r <= LHS_W'(s3_r.dw_r) * LHS_W'(s3_r.it.h);
      rhs_r   <= RHS_W'({s3_r.it.w, {FB{1'b0}}}) * RHS_W'(fh_e);
    end
  end

  // Stage 5: pick the fit division for each fit.
  cside_t          s5_r;
  logic            s5_v_r;
  logic            cond_a, cond_r, cond_r_r;
  logic [C_N-1:0]  num_a_r, num_r_r;
  logic [DW_W-1:0] den_a_r, den_r_r;
  logic [C_N-1:0]  num_w, num_h;

  assign cond_a = lhs_a_r >= LHS_W'(rhs_r);
  assign cond_r = lhs_r_r >= LHS_W'(rhs_r);
  assign num_w  = {s4_r.it.w, {(2*FB){1'b0}}};
  assign num_h  = C_N'({s4_r.it.h, {FB{1'b0}}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (en) begin
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_r.fx     <= s4_r;
      s5_r.cond_a <= cond_a;
      cond_r_r    <= cond_r;
      num_a_r     <= cond_a ? num_w : num_h;
      den_a_r     <= cond_a ? s4_r.dw_a : DW_W'(fh_e);
      num_r_r     <= cond_r ? num_w : num_h;
      den_r_r     <= cond_r ? s4_r.dw_r : DW_W'(fh_e);
    end
  end

  // Fit scales of the aspect-corrected fit and the requested fit.
  logic           ca_v, cr_v;
  logic [C_N-1:0] ca_q, cr_q;
  cside_t         ca_side;
  logic           cr_side;

  vfl_div #(.N(C_N), .D(DW_W), .SW($bits(cside_t))) u_div_scale_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s5_v_r),
    .in_num   (num_a_r),
    .in_den   (den_a_r),
    .in_side  (s5_r),
    .out_valid(ca_v),
    .out_quo  (ca_q),
    .out_side (ca_side)
  );

  vfl_div #(.N(C_N), .D(DW_W), .SW(1)) u_div_scale_r (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s5_v_r),
    .in_num   (num_r_r),
    .in_den   (den_r_r),
    .in_side  (cond_r_r),
    .out_valid(cr_v),
    .out_quo  (cr_q),
    .out_side (cr_side)
  );

  function automatic logic [SCL_W-1:0] fit_scale_of(input logic [C_N-1:0] q,
                                                   input logic int_mode);
    logic [SCL_W-1:0] s;
    logic [SCL_W-1:0] fl;
    s  = sat_scl(64'(q));
    fl = s & ~(vfl_pkg::QONE - SCL_W'(1));
    if (!int_mode) begin
      return s;
    end
    return (fl < vfl_pkg::QONE) ? vfl_pkg::QONE : fl;
  endfunction

  // Stage 6: saturated and optionally floored scales.
  cside_t           s6_r;
  logic             s6_cond_r_r;
  logic [SCL_W-1:0] s6_sa_r, s6_sr_r;
  logic             s6_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else if (en) begin
      s6_v_r <= ca_v & cr_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_r        <= ca_side;
      s6_cond_r_r <= cr_side;
      s6_sa_r     <= fit_scale_of(ca_q, integ);
      s6_sr_r     <= fit_scale_of(cr_q, integ);
    end
  end

  // Stage 7: products with the scales.
  prod_t s7_r, s7_nxt;
  logic  s7_v_r;

  always_comb begin
    s7_nxt.it     = s6_r.fx.it;
    s7_nxt.xs_a   = s6_r.fx.xs_a;
    s7_nxt.cond_a = s6_r.cond_a;
    s7_nxt.cond_r = s6_cond_r_r;
    s7_nxt.s_a    = s6_sa_r;
    s7_nxt.s_r    = s6_sr_r;
    s7_nxt.dws_a  = DWS_W'(s6_r.fx.dw_a) * DWS_W'(s6_sa_r);
    s7_nxt.fhs_a  = FHS_W'(fh_e) * FHS_W'(s6_sa_r);
    s7_nxt.dws_r  = DWS_W'(s6_r.fx.dw_r) * DWS_W'(s6_sr_r);
    s7_nxt.fhs_r  = FHS_W'(fh_e) * FHS_W'(s6_sr_r);
    s7_nxt.alxs   = ALX_W'(al_r) * ALX_W'(s6_r.fx.xs_r);
    s7_nxt.awxs   = AWX_W'(aw_r) * AWX_W'(s6_r.fx.xs_r);
    s7_nxt.ats    = ATS_W'(at_r) * ATS_W'(s6_sr_r);
    s7_nxt.ahs    = AHS_W'(ah_r) * AHS_W'(s6_sr_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_v_r <= 1'b0;
    end else if (en) begin
      s7_v_r <= s6_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_r <= s7_nxt;
    end
  end

  // Stage 8: paddings and the second rectangle products.
  pad_t        s8_r, s8_nxt;
  logic        s8_v_r;
  logic [63:0] wq8, hq8;

  assign wq8 = 64'({s7_r.it.w, {FB{1'b0}}});
  assign hq8 = 64'({s7_r.it.h, {FB{1'b0}}});

  always_comb begin
    s8_nxt.it     = s7_r.it;
    s8_nxt.xs_a   = s7_r.xs_a;
    s8_nxt.s_a    = s7_r.s_a;
    s8_nxt.padx_a = (s7_r.cond_a && !integ) ? '0 : half_pos(wq8, 64'(s7_r.dws_a) >> FB);
    s8_nxt.pady_a = (!s7_r.cond_a && !integ) ? '0 : half_pos(hq8, 64'(s7_r.fhs_a));
    s8_nxt.padx_r = (s7_r.cond_r && !integ) ? '0 : half_pos(wq8, 64'(s7_r.dws_r) >> FB);
    s8_nxt.pady_r = (!s7_r.cond_r && !integ) ? '0 : half_pos(hq8, 64'(s7_r.fhs_r));
    s8_nxt.alxss  = ALXS_W'(s7_r.alxs) * ALXS_W'(s7_r.s_r);
    s8_nxt.awxss  = AWXS_W'(s7_r.awxs) * AWXS_W'(s7_r.s_r);
    s8_nxt.ats    = s7_r.ats;
    s8_nxt.ahs    = s7_r.ahs;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_v_r <= 1'b0;
    end else if (en) begin
      s8_v_r <= s7_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_r <= s8_nxt;
    end
  end

  // Stage 9: rectangle and pointer offsets.
  dside_t           s9_r, s9_nxt;
  fside_t           s9f_r, s9f_nxt;
  logic [NUM_W-1:0] numx_r, numy_r, numx_nxt, numy_nxt;
  logic             s9_v_r;
  logic [63:0]      lsum, tsum;
  logic [NUM_W-1:0] vx, vy;

  always_comb begin
    lsum = ((64'(s8_r.alxss) >> FB) + 64'(s8_r.padx_r)) >> FB;
    tsum = ((64'(s8_r.ats) + 64'(s8_r.pady_r)) >> FB) + 64'(s8_r.it.m);
    s9_nxt.rect_left   = sat_rect(lsum);
    s9_nxt.rect_top    = sat_rect(tsum);
    s9_nxt.rect_width  = sat_rect(64'(s8_r.awxss) >> (2 * FB));
    s9_nxt.rect_height = sat_rect(64'(s8_r.ahs) >> FB);
    s9_nxt.fit_scale   = s8_r.s_a;
    s9_nxt.horiz_scale = s8_r.xs_a;
    vx = NUM_W'({s8_r.it.px, {FB{1'b0}}});
    vy = NUM_W'({(PTR_W+1)'(s8_r.it.py) + (PTR_W+1)'(s8_r.it.m), {FB{1'b0}}});
    s9_nxt.neg_x  = vx < s8_r.padx_a;
    numx_nxt      = s9_nxt.neg_x ? s8_r.padx_a - vx : vx - s8_r.padx_a;
    s9_nxt.nz_x   = numx_nxt != '0;
    s9f_nxt.neg_y = vy < s8_r.pady_a;
    numy_nxt      = s9f_nxt.neg_y ? s8_r.pady_a - vy : vy - s8_r.pady_a;
    s9f_nxt.nz_y  = numy_nxt != '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s9_v_r <= 1'b0;
    end else if (en) begin
      s9_v_r <= s8_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s9_r   <= s9_nxt;
      s9f_r  <= s9f_nxt;
      numx_r <= numx_nxt;
      numy_r <= numy_nxt;
    end
  end

  // Pointer divisions by the fit scale.
  logic           d_v, f_v;
  logic [D_N-1:0] d_q, f_q;
  dside_t         d_side;
  fside_t         f_side;

  vfl_div #(.N(D_N), .D(SCL_W), .SW($bits(dside_t))) u_div_ptr_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s9_v_r),
    .in_num   ({numx_r, {FB{1'b0}}}),
    .in_den   (s9_r.fit_scale),
    .in_side  (s9_r),
    .out_valid(d_v),
    .out_quo  (d_q),
    .out_side (d_side)
  );

  vfl_div #(.N(D_N), .D(SCL_W), .SW($bits(fside_t))) u_div_ptr_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s9_v_r),
    .in_num   (D_N'({numy_r, {SRC_FB{1'b0}}})),
    .in_den   (s9_r.fit_scale),
    .in_side  (s9f_r),
    .out_valid(f_v),
    .out_quo  (f_q),
    .out_side (f_side)
  );

  // Stage 10: clamp the first x quotient and finish y.
  eside_t          s10_r, s10_nxt;
  logic [Q1_W-1:0] q1_r, q1_nxt;
  logic            s10_v_r;

  always_comb begin
    q1_nxt = '0;
    if (d_side.nz_x) begin
      q1_nxt = (d_q > D_N'(Q1_MAX)) ? Q1_MAX : d_q[Q1_W-1:0];
    end
    s10_nxt.d     = d_side;
    s10_nxt.sy    = sgn_out(f_side.neg_y, f_side.nz_y ? E_N'(f_q) : '0);
    s10_nxt.q1_nz = q1_nxt != '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s10_v_r <= 1'b0;
    end else if (en) begin
      s10_v_r <= d_v & f_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s10_r <= s10_nxt;
      q1_r  <= q1_nxt;
    end
  end

  // Second x division by the horizontal scale.
  logic           e_v;
  logic [E_N-1:0] e_q;
  eside_t         e_side;

  vfl_div #(.N(E_N), .D(SCL_W), .SW($bits(eside_t))) u_div_ptr_xs (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s10_v_r),
    .in_num   ({q1_r, {SRC_FB{1'b0}}}),
    .in_den   (s10_r.d.horiz_scale),
    .in_side  (s10_r),
    .out_valid(e_v),
    .out_quo  (e_q),
    .out_side (e_side)
  );

  // Output register.
  res_t res_nxt;

  always_comb begin
    res_nxt.rect_left   = e_side.d.rect_left;
    res_nxt.rect_top    = e_side.d.rect_top;
    res_nxt.rect_width  = e_side.d.rect_width;
    res_nxt.rect_height = e_side.d.rect_height;
    res_nxt.fit_scale   = e_side.d.fit_scale;
    res_nxt.horiz_scale = e_side.d.horiz_scale;
    res_nxt.source_x    = sgn_out(e_side.d.neg_x, e_side.q1_nz ? e_q : '0);
    res_nxt.source_y    = e_side.sy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= e_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_rect_left   = res_r.rect_left;
  assign out_rect_top    = res_r.rect_top;
  assign out_rect_width  = res_r.rect_width;
  assign out_rect_height = res_r.rect_height;
  assign out_fit_scale   = res_r.fit_scale;
  assign out_horiz_scale = res_r.horiz_scale;
  assign out_source_x    = res_r.source_x;
  assign out_source_y    = res_r.source_y;

endmodule

### verif/tb_top.sv
// Self-checking testbench for viewport_fit_letterbox_unit: directed and random requests,
// register settings in phases, random stalls on both channels, results checked in order.
// Depends on vfl_pkg and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module tb_top;

  localparam int FRACTION_BITS = vfl_pkg::FRACTION_BITS;
  localparam int WIN_W         = vfl_pkg::WIN_W;
  localparam int PTR_W         = vfl_pkg::PTR_W;
  localparam int RECT_W        = vfl_pkg::RECT_W;
  localparam int SCL_W         = vfl_pkg::SCL_W;
  localparam int SRC_W         = vfl_pkg::SRC_W;
  localparam int SRC_FB        = vfl_pkg::SRC_FB;
  localparam int CFG_IDX_W     = vfl_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W    = vfl_pkg::CFG_DATA_W;
  localparam int MODE_STRETCH  = vfl_pkg::MODE_STRETCH;
  localparam int MODE_INTEGER  = vfl_pkg::MODE_INTEGER;

  typedef bit [63:0] u64;

  localparam u64 QMAX = 64'hFFFFFF;
  localparam u64 RMAX = 64'hFFFF;
  localparam u64 SPOS = 64'h7FFFFF;
  localparam u64 SNEG = 64'h800000;
  localparam u64 UNITY = u64'(1) << FRACTION_BITS;
  localparam int SETTLE_CYCLES = 300;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    bit [WIN_W-1:0] window_w;
    bit [WIN_W-1:0] window_h;
    bit [PTR_W-1:0] margin_top;
    bit             use_aspect;
    bit [PTR_W-1:0] pointer_x;
    bit [PTR_W-1:0] pointer_y;
  } view_req_t;

  typedef struct {
    bit [RECT_W-1:0] rect_left;
    bit [RECT_W-1:0] rect_top;
    bit [RECT_W-1:0] rect_width;
    bit [RECT_W-1:0] rect_height;
    bit [SCL_W-1:0]  fit_scale;
    bit [SCL_W-1:0]  horiz_scale;
    bit [SRC_W-1:0]  source_x;
    bit [SRC_W-1:0]  source_y;
  } view_fit_t;

  class fit_scoreboard;
    u64 frame_w, frame_h, act_left, act_top, act_w, act_h, aspect, mode;
    view_fit_t fits_due[$];
    int errors;

    function new();
      frame_w = 640; frame_h = 480; act_left = 0; act_top = 0;
      act_w = 640; act_h = 480; aspect = 87381; mode = 0;
      errors = 0;
    endfunction

    function void set_reg(vfl_pkg::cfg_idx_t idx, u64 val);
      case (idx)
        vfl_pkg::CFG_FRAME_WIDTH:   frame_w  = val & 64'h1FFF;
        vfl_pkg::CFG_FRAME_HEIGHT:  frame_h  = val & 64'h1FFF;
        vfl_pkg::CFG_ACTIVE_LEFT:   act_left = val & 64'hFFF;
        vfl_pkg::CFG_ACTIVE_TOP:    act_top  = val & 64'hFFF;
        vfl_pkg::CFG_ACTIVE_WIDTH:  act_w    = val & 64'h1FFF;
        vfl_pkg::CFG_ACTIVE_HEIGHT: act_h    = val & 64'h1FFF;
        vfl_pkg::CFG_TARGET_ASPECT: aspect   = val & QMAX;
        vfl_pkg::CFG_FIT_MODE:      mode     = val & 64'h3;
        default: ;
      endcase
    endfunction

    function u64 clip(u64 v, u64 m);
      return (v > m) ? m : v;
    endfunction

    function u64 half_gap(u64 a, u64 b);
      return (a > b) ? (a - b) >> 1 : 0;
    endfunction

    function bit [SRC_W-1:0] to_signed(bit neg, u64 mag);
      u64 r;
      if (neg) begin
        r = (64'd0 - clip(mag, SNEG)) & QMAX;
      end else begin
        r = clip(mag, SPOS);
      end
      return r[SRC_W-1:0];
    endfunction

    function void fit(bit corr, u64 w, u64 h, output u64 xs, output u64 s,
                      output u64 pad_x, output u64 pad_y);
      u64 fw, fh, wq, hq, da, dw;
      bit integ;
      fw = frame_w ? frame_w : 1;
      fh = frame_h ? frame_h : 1;
      integ = mode[MODE_INTEGER];
      wq = w << FRACTION_BITS;
      hq = h << FRACTION_BITS;
      da = mode[MODE_STRETCH] ? clip(wq / h, QMAX) : aspect;
      xs = corr ? clip(da * fh / fw, QMAX) : UNITY;
      dw = fw * xs;
      if (dw * h >= wq * fh) begin
        s = dw ? clip((wq << FRACTION_BITS) / dw, QMAX) : QMAX;
        if (integ) begin
          s = s & ~(UNITY - 1);
          if (s < UNITY) s = UNITY;
        end
        pad_x = integ ? half_gap(wq, (dw * s) >> FRACTION_BITS) : 0;
        pad_y = half_gap(hq, fh * s);
      end else begin
        s = clip(hq / fh, QMAX);
        if (integ) begin
          s = s & ~(UNITY - 1);
          if (s < UNITY) s = UNITY;
        end
        pad_x = half_gap(wq, (dw * s) >> FRACTION_BITS);
        pad_y = integ ? half_gap(hq, fh * s) : 0;
      end
    endfunction

    function view_fit_t compute_fit(view_req_t rq);
      view_fit_t f;
      u64 w, m, h, v, num, q1, q2;
      u64 rxs, rs, rpx, rpy, axs, as_, apx, apy;
      bit neg;
      w = u64'(rq.window_w);
      m = u64'(rq.margin_top);
      h = (u64'(rq.window_h) > m) ? u64'(rq.window_h) - m : u64'(1);
      fit(rq.use_aspect, w, h, rxs, rs, rpx, rpy);
      fit(1'b1, w, h, axs, as_, apx, apy);
      v = ((act_left * rxs * rs) >> FRACTION_BITS) + rpx;
      f.rect_left = RECT_W'(clip(v >> FRACTION_BITS, RMAX));
      v = ((act_top * rs + rpy) >> FRACTION_BITS) + m;
      f.rect_top = RECT_W'(clip(v, RMAX));
      v = (act_w * rxs * rs) >> (2 * FRACTION_BITS);
      f.rect_width = RECT_W'(clip(v, RMAX));
      f.rect_height = RECT_W'(clip((act_h * rs) >> FRACTION_BITS, RMAX));
      f.fit_scale = SCL_W'(clip(as_, QMAX));
      f.horiz_scale = SCL_W'(clip(axs, QMAX));
      v = u64'(rq.pointer_x) << FRACTION_BITS;
      neg = v < apx;
      num = neg ? apx - v : v - apx;
      if (as_ != 0) q1 = clip((num << FRACTION_BITS) / as_, u64'(1) << 40);
      else q1 = num ? (u64'(1) << 40) : 0;
      if (axs != 0) q2 = (q1 << SRC_FB) / axs;
      else q2 = q1 ? SNEG : 0;
      f.source_x = to_signed(neg, q2);
      v = (u64'(rq.pointer_y) + m) << FRACTION_BITS;
      neg = v < apy;
      num = neg ? apy - v : v - apy;
      if (as_ != 0) q2 = (num << SRC_FB) / as_;
      else q2 = num ? SNEG : 0;
      f.source_y = to_signed(neg, q2);
      return f;
    endfunction

    function void note_request(view_req_t rq);
      fits_due.push_back(compute_fit(rq));
    endfunction

    function void field_check(string name, u64 exp_v, u64 act_v);
      if (exp_v != act_v) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(view_fit_t got);
      view_fit_t e;
      if (fits_due.size() == 0) begin
        $error("result arrived with no request outstanding");
        errors++;
        return;
      end
      e = fits_due.pop_front();
      field_check("rect_left", u64'(e.rect_left), u64'(got.rect_left));
      field_check("rect_top", u64'(e.rect_top), u64'(got.rect_top));
      field_check("rect_width", u64'(e.rect_width), u64'(got.rect_width));
      field_check("rect_height", u64'(e.rect_height), u64'(got.rect_height));
      field_check("fit_scale", u64'(e.fit_scale), u64'(got.fit_scale));
      field_check("horiz_scale", u64'(e.horiz_scale), u64'(got.horiz_scale));
      field_check("source_x", u64'(e.source_x), u64'(got.source_x));
      field_check("source_y", u64'(e.source_y), u64'(got.source_y));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [WIN_W-1:0] in_window_w = '0;
  logic [WIN_W-1:0] in_window_h = '0;
  logic [PTR_W-1:0] in_margin_top = '0;
  logic in_use_aspect = 1'b0;
  logic [PTR_W-1:0] in_pointer_x = '0;
  logic [PTR_W-1:0] in_pointer_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [RECT_W-1:0] out_rect_left, out_rect_top, out_rect_width, out_rect_height;
  logic [SCL_W-1:0] out_fit_scale, out_horiz_scale;
  logic signed [SRC_W-1:0] out_source_x, out_source_y;

  fit_scoreboard sb = new();
  int in_idle_pct = 32;
  int out_idle_pct = 32;
  int hold_left = 0;
  int cycles = 0;

  viewport_fit_letterbox_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_window_w(in_window_w), .in_window_h(in_window_h),
    .in_margin_top(in_margin_top), .in_use_aspect(in_use_aspect),
    .in_pointer_x(in_pointer_x), .in_pointer_y(in_pointer_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_rect_left(out_rect_left), .out_rect_top(out_rect_top),
    .out_rect_width(out_rect_width), .out_rect_height(out_rect_height),
    .out_fit_scale(out_fit_scale), .out_horiz_scale(out_horiz_scale),
    .out_source_x(out_source_x), .out_source_y(out_source_y)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** viewport_fit_letterbox_unit: FAILED **");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    view_fit_t got;
    if (rst_n && out_valid && out_ready) begin
      got.rect_left = out_rect_left;
      got.rect_top = out_rect_top;
      got.rect_width = out_rect_width;
      got.rect_height = out_rect_height;
      got.fit_scale = out_fit_scale;
      got.horiz_scale = out_horiz_scale;
      got.source_x = out_source_x;
      got.source_y = out_source_y;
      sb.check_result(got);
    end
  end

  task automatic send_view(view_req_t rq);
    @(negedge clk);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_window_w <= rq.window_w;
    in_window_h <= rq.window_h;
    in_margin_top <= rq.margin_top;
    in_use_aspect <= rq.use_aspect;
    in_pointer_x <= rq.pointer_x;
    in_pointer_y <= rq.pointer_y;
    do @(posedge clk); while (!in_ready);
    sb.note_request(rq);
  endtask

  task automatic send_fixed(int w, int h, int m, bit ua, int px, int py);
    view_req_t rq;
    rq.window_w = WIN_W'(w); rq.window_h = WIN_W'(h); rq.margin_top = PTR_W'(m);
    rq.use_aspect = ua; rq.pointer_x = PTR_W'(px); rq.pointer_y = PTR_W'(py);
    send_view(rq);
  endtask

  task automatic send_random();
    view_req_t rq;
    if ($urandom_range(0, 3) == 0) begin
      rq.window_w = WIN_W'($urandom);
      rq.window_h = WIN_W'($urandom);
      rq.margin_top = PTR_W'($urandom);
    end else begin
      rq.window_w = WIN_W'($urandom_range(1, 4096));
      rq.window_h = WIN_W'($urandom_range(1, 4096));
      rq.margin_top = PTR_W'($urandom_range(0, 64));
    end
    rq.use_aspect = 1'($urandom);
    rq.pointer_x = PTR_W'($urandom);
    rq.pointer_y = PTR_W'($urandom);
    send_view(rq);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.fits_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(vfl_pkg::cfg_idx_t idx, int unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    sb.set_reg(idx, u64'(val));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(int unsigned fw, int unsigned fh, int unsigned al,
                           int unsigned at, int unsigned aw, int unsigned ah,
                           int unsigned asp, int unsigned md);
    write_reg(vfl_pkg::CFG_FRAME_WIDTH, fw);
    write_reg(vfl_pkg::CFG_FRAME_HEIGHT, fh);
    write_reg(vfl_pkg::CFG_ACTIVE_LEFT, al);
    write_reg(vfl_pkg::CFG_ACTIVE_TOP, at);
    write_reg(vfl_pkg::CFG_ACTIVE_WIDTH, aw);
    write_reg(vfl_pkg::CFG_ACTIVE_HEIGHT, ah);
    write_reg(vfl_pkg::CFG_TARGET_ASPECT, asp);
    write_reg(vfl_pkg::CFG_FIT_MODE, md);
  endtask

  task automatic random_setting(int unsigned md);
    bit wide;
    wide = ($urandom_range(0, 3) == 0);
    write_all(wide ? $urandom : $urandom_range(1, 1024),
              wide ? $urandom : $urandom_range(1, 1024),
              wide ? $urandom : $urandom_range(0, 64),
              wide ? $urandom : $urandom_range(0, 64),
              wide ? $urandom : $urandom_range(1, 1024),
              wide ? $urandom : $urandom_range(1, 1024),
              wide ? $urandom : $urandom_range(32768, 196608), md);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_fixed(640, 480, 0, 1, 0, 0);
    send_fixed(16383, 16383, 0, 1, 8191, 8191);
    send_fixed(1, 1, 0, 1, 8191, 8191);
    send_fixed(100, 50, 60, 1, 20, 30);
    send_fixed(800, 600, 8191, 0, 400, 300);
    send_fixed(0, 600, 0, 1, 5, 5);
    send_fixed(1920, 1080, 40, 0, 0, 8191);
    send_fixed(1024, 4096, 1, 1, 512, 0);
    wait_idle();

    write_all(0, 0, 4095, 4095, 8191, 8191, 16777215, 3);
    send_fixed(16383, 16383, 0, 1, 8191, 8191);
    send_fixed(1, 1, 0, 0, 0, 0);
    send_fixed(3000, 200, 100, 1, 1500, 0);
    send_fixed(200, 3000, 0, 1, 0, 1500);
    wait_idle();

    write_all(1, 1, 0, 0, 0, 0, 0, 2);
    send_fixed(640, 480, 0, 1, 100, 100);
    send_fixed(0, 0, 0, 1, 0, 0);
    send_fixed(500, 500, 499, 0, 8191, 0);
    wait_idle();

    write_all(320, 240, 16, 8, 288, 224, 87381, 1);
    send_fixed(1280, 720, 0, 1, 640, 360);
    send_fixed(720, 1280, 24, 0, 0, 0);
    send_fixed(16383, 1, 0, 1, 8191, 0);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      random_setting(ph % 4);
      if (ph == 2) begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end
      if (ph == 5) begin
        hold_left = 500;
        repeat (300) send_random();
      end else begin
        repeat (60) send_random();
      end
      in_idle_pct = 32;
      out_idle_pct = 32;
      wait_idle();
    end

    if (sb.errors == 0 && sb.fits_due.size() == 0) begin
      $display("** viewport_fit_letterbox_unit: PASSED **");
    end else begin
      $display("** viewport_fit_letterbox_unit: FAILED **");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/vfl_pkg.sv
hw/rtl/vfl_div.sv
hw/rtl/viewport_fit_letterbox_unit.sv
verif/tb_top.sv
